// File: rtl/ssr_pkg.sv
`default_nettype none

package ssr_pkg;

    // shape_mode register codes
    typedef enum logic [1:0] {
        MODE_SINE   = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_COSINE = 2'd2,
        MODE_BYPASS = 2'd3
    } shape_mode_t;

    // how the interpolated sine value becomes the weight
    typedef enum logic [1:0] {
        WF_DIRECT = 2'd0,   // w = S
        WF_COMPL  = 2'd1,   // w = 1.0 - S
        WF_ADD    = 2'd2    // w = 1.0 + S
    } wfold_t;

    // phase units: 0.12 deg per step, 750 steps to 90 deg
    localparam int unsigned QUARTER   = 750;
    localparam int unsigned HALF_TURN = 1500;
    localparam int unsigned ONE_Q15   = 32768;

    // x / 30 for x <= 750: (x * 2185) >> 16
    localparam int unsigned DIV30_MUL   = 2185;
    localparam int unsigned DIV30_SH    = 16;
    localparam int unsigned SEG_LEN     = 30;
    // v / 30 for v < 2^16: (v * 34953) >> 20
    localparam int unsigned INTERP_MUL  = 34953;
    localparam int unsigned INTERP_SH   = 20;
    localparam int unsigned INTERP_BIAS = 15;

    // linear increment: floor(|err| * 2^16 / L)
    localparam int unsigned LIN_SCALE = 65536;
    localparam int unsigned RECIP_SH  = 36;

    typedef struct packed {
        logic [9:0] x;      // sine argument, 0..750
        wfold_t     fold;
    } weight_req_t;

    typedef struct packed {
        logic        step;  // linear ramp beat: accumulate and report
        logic        clear; // end of run: zero the accumulator afterwards
        logic        neg;   // error sign
        logic [15:0] mag;   // error magnitude
    } acc_req_t;

    // sin at 3.6 deg spacing in Q1.15; index 25 and above is 1.0
    function automatic logic [15:0] sine_entry(input logic [4:0] idx);
        logic [15:0] v;
        unique case (idx)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd2058;
            5'd2:    v = 16'd4107;
            5'd3:    v = 16'd6140;
            5'd4:    v = 16'd8149;
            5'd5:    v = 16'd10126;
            5'd6:    v = 16'd12063;
            5'd7:    v = 16'd13952;
            5'd8:    v = 16'd15786;
            5'd9:    v = 16'd17558;
            5'd10:   v = 16'd19261;
            5'd11:   v = 16'd20887;
            5'd12:   v = 16'd22431;
            5'd13:   v = 16'd23887;
            5'd14:   v = 16'd25248;
            5'd15:   v = 16'd26510;
            5'd16:   v = 16'd27667;
            5'd17:   v = 16'd28715;
            5'd18:   v = 16'd29649;
            5'd19:   v = 16'd30467;
            5'd20:   v = 16'd31164;
            5'd21:   v = 16'd31739;
            5'd22:   v = 16'd32188;
            5'd23:   v = 16'd32510;
            5'd24:   v = 16'd32703;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ssr_weight.sv
`default_nettype none

// Two-stage weight lookup: segment split + table + slope, then interpolate + fold.
module ssr_weight (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire ssr_pkg::weight_req_t req,
    output logic        [16:0]      w
);
    import ssr_pkg::*;

    logic [21:0] i_prod;
    logic [4:0]  idx;
    logic [9:0]  f_full;
    logic [4:0]  f;
    logic [15:0] ti;
    logic [15:0] tn;
    logic [15:0] d;
    logic [15:0] num;

    logic [15:0] ti_reg;
    logic [15:0] num_reg;
    wfold_t      fold_reg;

    logic [31:0] interp_prod;
    logic [15:0] s;
    logic [16:0] w_next;
    logic [16:0] w_reg;

    assign i_prod = 22'(req.x) * 22'(DIV30_MUL);
    assign idx    = i_prod[DIV30_SH +: 5];
    assign f_full = req.x - 10'(10'(idx) * 10'(SEG_LEN));
    assign f      = f_full[4:0];
    assign ti     = sine_entry(idx);
    assign tn     = sine_entry(idx + 5'd1);
    assign d      = tn - ti;
    assign num    = 16'(16'(d[11:0]) * 16'(f)) + 16'(INTERP_BIAS);

    always_ff @(posedge aclk) begin
        if (en) begin
            ti_reg   <= ti;
            num_reg  <= num;
            fold_reg <= req.fold;
        end
    end

    assign interp_prod = 32'(num_reg) * 32'(INTERP_MUL);
    assign s = ti_reg + {4'd0, interp_prod[INTERP_SH +: 12]};

    always_comb begin
        case (fold_reg)
            WF_COMPL: w_next = 17'(ONE_Q15) - {1'b0, s};
            WF_ADD:   w_next = 17'(ONE_Q15) + {1'b0, s};
            default:  w_next = {1'b0, s};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg <= w_next;
        end
    end

    assign w = w_reg;

endmodule

`default_nettype wire

// File: rtl/ssr_accum.sv
`default_nettype none

// Linear ramp: per-beat increment by reciprocal multiply, then saturating Q16 accumulator.
module ssr_accum #(
    parameter int unsigned LINEAR_STEPS = 750
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire ssr_pkg::acc_req_t    req,
    output logic signed [39:0]        acc_out
);
    import ssr_pkg::*;

    // a * 2^16 / L = a * Q + a * R / L
    localparam int unsigned LIN_Q = LIN_SCALE / LINEAR_STEPS;
    localparam int unsigned LIN_R = LIN_SCALE % LINEAR_STEPS;
    localparam logic [32:0] RECIP_M =
        33'(((64'd1 << RECIP_SH) + 64'(LINEAR_STEPS) - 64'd1) / 64'(LINEAR_STEPS));
    localparam logic signed [39:0] ACC_MAX = {1'b0, {39{1'b1}}};
    localparam logic signed [39:0] ACC_MIN = {1'b1, {39{1'b0}}};

    logic        step2_reg, clear2_reg, neg2_reg;
    logic [28:0] aq_reg;
    logic [25:0] n_reg;

    logic        step3_reg, clear3_reg;
    logic [58:0] rp;
    logic [28:0] q;
    logic signed [29:0] inc_next;
    logic signed [29:0] inc_reg;

    logic signed [40:0] sum;
    logic signed [39:0] sat;
    logic signed [39:0] acc_reg;
    logic signed [39:0] acc_next;
    logic signed [39:0] acc_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step2_reg  <= 1'b0;
            clear2_reg <= 1'b0;
            step3_reg  <= 1'b0;
            clear3_reg <= 1'b0;
        end else if (en) begin
            step2_reg  <= req.step;
            clear2_reg <= req.clear;
            step3_reg  <= step2_reg;
            clear3_reg <= clear2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg2_reg <= req.neg;
            aq_reg   <= 29'(req.mag) * 29'(LIN_Q);
            n_reg    <= 26'(req.mag) * 26'(LIN_R);
            inc_reg  <= inc_next;
        end
    end

    assign rp       = 59'(n_reg) * 59'(RECIP_M);
    assign q        = aq_reg + 29'(rp[58:RECIP_SH]);
    assign inc_next = neg2_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});

    assign sum = {acc_reg[39], acc_reg} + 41'(inc_reg);

    always_comb begin
        if (sum[40] != sum[39]) begin
            sat = sum[40] ? ACC_MIN : ACC_MAX;
        end else begin
            sat = sum[39:0];
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (clear3_reg) begin
            acc_next = '0;
        end else if (step3_reg) begin
            acc_next = sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (en) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_out_reg <= sat;
        end
    end

    assign acc_out = acc_out_reg;

endmodule

`default_nettype wire

// File: rtl/soft_start_setpoint_ramp.sv
`default_nettype none

// Soft-start shaper for a speed setpoint. Each input beat carries the present
// value and the requested target; each beat yields exactly one output beat in
// order. A zero target arms the ramp (that same beat is already ramped). While
// armed, the output moves from the present value toward the target: sine mode
// weights the error by sin(n * 0.12 deg), cosine mode by 1 - cos(n * 0.12 deg),
// linear mode adds error / LINEAR_STEPS to a Q16 accumulator. Once step n passes
// the active mode's step count the run ends and the target passes through with
// ramp_active low. shape_mode is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while no beat is in flight; the block does not
// enforce this. Rate: one beat per clock while not stalled. Output valid rises
// once the beat has passed six registers: input register, state update, weight
// segment / increment, weight fold / accumulator input, multiply / accumulate,
// round and saturate into the output register. The whole pipe advances
// together; when the output beat is held (m_tready low) s_tready drops in the
// same cycle. s_tready is low during reset. No clearing pass after reset.
module soft_start_setpoint_ramp #(
    parameter int unsigned SINE_STEPS   = 750,
    parameter int unsigned COS_STEPS    = 600,
    parameter int unsigned LINEAR_STEPS = 750
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: shape_mode
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] current_value, [31:16] target_value
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] shaped_value
    output logic [0:0]       m_tuser    // [0] ramp_active
);
    import ssr_pkg::*;

    localparam logic [9:0] SINE_LIM = 10'(SINE_STEPS);
    localparam logic [9:0] COS_LIM  = 10'(COS_STEPS);
    localparam logic [9:0] LIN_LIM  = 10'(LINEAR_STEPS);
    localparam logic [9:0] MAX_LIM  =
        (SINE_LIM > COS_LIM) ? ((SINE_LIM > LIN_LIM) ? SINE_LIM : LIN_LIM)
                             : ((COS_LIM > LIN_LIM) ? COS_LIM : LIN_LIM);

    logic en;

    shape_mode_t mode_reg;

    // stage 0: input register
    logic        v0_reg;
    logic [15:0] cur0_reg, tgt0_reg;

    // run state
    logic        armed_reg, armed_next;
    logic [9:0]  step_count_reg, step_count_next;

    // stage 1 combinational
    logic               ramp;
    logic               run_end;
    logic [10:0]        p;
    logic [9:0]         sc_inc;
    logic [9:0]         limit;
    weight_req_t        wreq;
    logic signed [16:0] err;
    logic [16:0]        err_abs;

    // stage 1..4 carries
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [15:0]        cur1_reg, cur2_reg, cur3_reg, cur4_reg;
    logic [15:0]        tgt1_reg, tgt2_reg, tgt3_reg, tgt4_reg;
    logic signed [16:0] err1_reg, err2_reg, err3_reg;
    logic               act1_reg, act2_reg, act3_reg, act4_reg;
    logic               lin1_reg, lin2_reg, lin3_reg, lin4_reg;
    weight_req_t        wreq1_reg;
    acc_req_t           areq1_reg;

    logic [16:0]        w;
    logic signed [39:0] acc;
    logic signed [34:0] prod4_reg;

    // stage 5 combinational
    logic signed [35:0] b_sum;
    logic signed [40:0] l_sum;
    logic signed [25:0] delta;
    logic signed [26:0] total;
    logic [15:0]        res;

    logic               m_valid_reg;
    logic [15:0]        m_data_reg;
    logic               m_user_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en && aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_SINE;
        end else if (cfg_wr_en) begin
            mode_reg <= shape_mode_t'(cfg_wr_data);
        end
    end

    // ---- stage 0 ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cur0_reg <= s_tdata[15:0];
            tgt0_reg <= s_tdata[31:16];
        end
    end

    // ---- stage 1: run state ----
    assign ramp   = (armed_reg || (tgt0_reg == 16'd0)) && (mode_reg != MODE_BYPASS);
    assign p      = {1'b0, step_count_reg} + 11'd1;
    assign sc_inc = step_count_reg + 10'd1;

    always_comb begin
        unique case (mode_reg)
            MODE_SINE:   limit = SINE_LIM;
            MODE_LINEAR: limit = LIN_LIM;
            MODE_COSINE: limit = COS_LIM;
            MODE_BYPASS: limit = '0;
        endcase
    end

    assign run_end = ramp && (sc_inc > limit);

    always_comb begin
        armed_next      = armed_reg;
        step_count_next = step_count_reg;
        if (en && v0_reg) begin
            if (ramp) begin
                armed_next      = !run_end;
                step_count_next = run_end ? 10'd0 : sc_inc;
            end else if (tgt0_reg == 16'd0) begin
                armed_next = 1'b1;   // bypass mode still arms
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg      <= 1'b0;
            step_count_reg <= '0;
        end else begin
            armed_reg      <= armed_next;
            step_count_reg <= step_count_next;
        end
    end

    // sine argument and fold for the weight
    always_comb begin
        wreq.x    = 10'(p);
        wreq.fold = WF_DIRECT;
        if (mode_reg == MODE_SINE) begin
            if (p > 11'(QUARTER)) begin
                wreq.x = 10'(11'(HALF_TURN) - p);
            end
        end else if (mode_reg == MODE_COSINE) begin
            if (p <= 11'(QUARTER)) begin
                wreq.x    = 10'(11'(QUARTER) - p);
                wreq.fold = WF_COMPL;
            end else begin
                wreq.x    = 10'(p - 11'(QUARTER));
                wreq.fold = WF_ADD;
            end
        end
    end

    assign err     = $signed({tgt0_reg[15], tgt0_reg}) - $signed({cur0_reg[15], cur0_reg});
    assign err_abs = err[16] ? 17'(-err) : 17'(err);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            areq1_reg <= '0;
        end else if (en) begin
            v1_reg          <= v0_reg;
            areq1_reg.step  <= v0_reg && ramp && (mode_reg == MODE_LINEAR);
            areq1_reg.clear <= v0_reg && run_end;
            areq1_reg.neg   <= err[16];
            areq1_reg.mag   <= err_abs[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cur1_reg  <= cur0_reg;
            tgt1_reg  <= tgt0_reg;
            err1_reg  <= err;
            act1_reg  <= ramp;
            lin1_reg  <= mode_reg == MODE_LINEAR;
            wreq1_reg <= wreq;
        end
    end

    // ---- stages 2..4: weight, linear increment and accumulator ----
    ssr_weight u_weight (
        .aclk (aclk),
        .en   (en),
        .req  (wreq1_reg),
        .w    (w)
    );

    ssr_accum #(
        .LINEAR_STEPS (LINEAR_STEPS)
    ) u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .req     (areq1_reg),
        .acc_out (acc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cur2_reg  <= cur1_reg;
            tgt2_reg  <= tgt1_reg;
            err2_reg  <= err1_reg;
            act2_reg  <= act1_reg;
            lin2_reg  <= lin1_reg;
            cur3_reg  <= cur2_reg;
            tgt3_reg  <= tgt2_reg;
            err3_reg  <= err2_reg;
            act3_reg  <= act2_reg;
            lin3_reg  <= lin2_reg;
            // ---- stage 4: blend multiply ----
            prod4_reg <= err3_reg * $signed({1'b0, w});
            cur4_reg  <= cur3_reg;
            tgt4_reg  <= tgt3_reg;
            act4_reg  <= act3_reg;
            lin4_reg  <= lin3_reg;
        end
    end

    // ---- stage 5: round half up, add, saturate ----
    assign b_sum = {prod4_reg[34], prod4_reg} + 36'(1 << 14);
    assign l_sum = {acc[39], acc} + 41'(1 << 15);
    assign delta = lin4_reg ? 26'($signed(l_sum[40:16])) : 26'($signed(b_sum[35:15]));
    assign total = 27'($signed(cur4_reg)) + 27'(delta);

    always_comb begin
        if (!act4_reg) begin
            res = tgt4_reg;
        end else if (total > 27'sd32767) begin
            res = 16'h7FFF;
        end else if (total < -27'sd32768) begin
            res = 16'h8000;
        end else begin
            res = total[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= res;
            m_user_reg <= act4_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    // ---- checks ----
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_count_reg <= MAX_LIM)
        else $error("step_count past longest run");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !armed_reg |-> step_count_reg == 10'd0)
        else $error("step_count nonzero while disarmed");

    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && v0_reg && run_end) |=> (!armed_reg && step_count_reg == 10'd0))
        else $error("run end did not clear state");

    a_run_go: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && v0_reg && ramp && !run_end) |=> (armed_reg && step_count_reg != 10'd0))
        else $error("ramped beat did not advance run");

endmodule

`default_nettype wire

// File: test/ssr_checker.sv
`default_nettype none

// Watches both streams of the setpoint ramp, predicts every output beat from
// the accepted input beats and the shape_mode writes, and compares in order.
module ssr_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] current_value, [31:16] target_value
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [15:0] shaped_value
    input  wire logic [0:0]  m_tuser,   // [0] ramp_active
    output int               fail_count,
    output int               pending,
    output int               n_results,
    output int               n_ramped,
    output int               n_runs_ended
);
    timeunit 1ns;
    timeprecision 1ps;
    import ssr_pkg::*;

    localparam int SINE_STEPS   = 750;
    localparam int COS_STEPS    = 600;
    localparam int LINEAR_STEPS = 750;
    localparam int QUARTER_PH   = 750;
    localparam int HALF_PH      = 1500;
    localparam int UNITY_Q15    = 32768;
    localparam longint ACC_HI   = 64'sd549755813887;
    localparam longint ACC_LO   = -64'sd549755813888;

    // sin at 3.6 deg spacing, Q1.15
    localparam int SINE_LUT [26] = '{
        0, 2058, 4107, 6140, 8149, 10126, 12063, 13952, 15786, 17558,
        19261, 20887, 22431, 23887, 25248, 26510, 27667, 28715, 29649, 30467,
        31164, 31739, 32188, 32510, 32703, 32768
    };

    typedef struct packed {
        logic signed [15:0] shaped;
        logic               active;
    } ramp_out_t;

    ramp_out_t   expected_out[$];

    // ramp state
    logic        armed;
    logic [9:0]  steps;
    longint      lin_acc;
    shape_mode_t mode;

    function automatic int sine_q15(input int ph);
        int seg;
        int frac;
        if (ph >= QUARTER_PH) return UNITY_Q15;
        seg  = ph / 30;
        frac = ph % 30;
        return SINE_LUT[seg] + ((SINE_LUT[seg + 1] - SINE_LUT[seg]) * frac + 15) / 30;
    endfunction

    // arithmetic shift, ties toward +inf
    function automatic longint round_shift(input longint v, input int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic ramp_out_t predict_step(input logic signed [15:0] cur,
                                               input logic signed [15:0] tgt);
        ramp_out_t r;
        longint    err;
        longint    acc;
        int        w;
        int        ph;
        int        limit;
        err      = longint'(tgt) - longint'(cur);
        r.shaped = tgt;
        r.active = 1'b0;
        limit    = 0;
        // arming comes first: the arming beat is already ramped
        if (tgt == 0) armed = 1'b1;
        if (armed && mode != MODE_BYPASS) begin
            ph = int'(steps) + 1;
            if (mode == MODE_LINEAR) begin
                acc = lin_acc + (err * 65536) / LINEAR_STEPS;
                if (acc > ACC_HI) acc = ACC_HI;
                if (acc < ACC_LO) acc = ACC_LO;
                lin_acc  = acc;
                r.shaped = 16'(clip16(longint'(cur) + round_shift(acc, 16)));
                limit    = LINEAR_STEPS;
            end else begin
                if (mode == MODE_SINE) begin
                    w     = sine_q15(ph > QUARTER_PH ? HALF_PH - ph : ph);
                    limit = SINE_STEPS;
                end else begin
                    w     = (ph <= QUARTER_PH) ? UNITY_Q15 - sine_q15(QUARTER_PH - ph)
                                               : UNITY_Q15 + sine_q15(ph - QUARTER_PH);
                    limit = COS_STEPS;
                end
                r.shaped = 16'(clip16(longint'(cur) + round_shift(err * longint'(w), 15)));
            end
            r.active = 1'b1;
            steps    = steps + 10'd1;
            if (int'(steps) > limit) begin
                steps   = '0;
                lin_acc = 0;
                armed   = 1'b0;
                n_runs_ended++;
            end
        end
        return r;
    endfunction

    task automatic log_error(input string what);
        fail_count++;
        if (fail_count <= 10) $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge aclk) begin
        ramp_out_t exp_out;
        if (!aresetn) begin
            armed   = 1'b0;
            steps   = '0;
            lin_acc = 0;
            mode    = MODE_SINE;
            expected_out.delete();
        end else begin
            // drain first, so a beat accepted now never matches itself
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_out.size() == 0) begin
                    log_error($sformatf("unexpected beat shaped=%0d active=%0d",
                                        $signed(m_tdata), m_tuser[0]));
                end else begin
                    exp_out = expected_out.pop_front();
                    if (exp_out.active) n_ramped++;
                    if ($signed(m_tdata) != exp_out.shaped)
                        log_error($sformatf("shaped_value exp %0d got %0d",
                                            exp_out.shaped, $signed(m_tdata)));
                    if (m_tuser[0] != exp_out.active)
                        log_error($sformatf("ramp_active exp %0d got %0d",
                                            exp_out.active, m_tuser[0]));
                end
            end
            if (s_tvalid && s_tready)
                expected_out.push_back(predict_step(s_tdata[15:0], s_tdata[31:16]));
            if (cfg_wr_en) mode = shape_mode_t'(cfg_wr_data);
        end
        pending = expected_out.size();
    end

endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

// Top of the ramp testbench: clock, reset, stimulus, output back-pressure and
// the verdict. Prediction and comparison live in ssr_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ssr_pkg::*;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = '0;  // [15:0] current_value, [31:16] target_value
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;           // [15:0] shaped_value
    logic [0:0]  m_tuser;           // [0] ramp_active

    int fail_count;
    int pending;
    int n_results;
    int n_ramped;
    int n_runs_ended;

    // idle controls, flipped per phase; the closing phase runs with both off
    bit          gaps_on  = 1'b0;
    bit          stall_on = 1'b0;
    int unsigned sink_hold = 0;

    always #5 aclk = ~aclk;

    soft_start_setpoint_ramp u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    ssr_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .pending     (pending),
        .n_results   (n_results),
        .n_ramped    (n_ramped),
        .n_runs_ended(n_runs_ended)
    );

    // Sink side: random stall bursts, changed on the falling edge.
    always @(negedge aclk) begin
        if (sink_hold != 0) begin
            m_tready = 1'b0;
            sink_hold--;
        end else if (stall_on && $urandom_range(0, 15) == 0) begin
            m_tready  = 1'b0;
            sink_hold = $urandom_range(0, 13);
        end else begin
            m_tready = 1'b1;
        end
    end

    // Field values weighted toward the corners: most negative, most positive,
    // minus one and plus one, else uniform over all 16 bits.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0001;
            default: return 16'($urandom());
        endcase
    endfunction

    // One input beat: optional gap first, then hold tvalid until the
    // handshake is seen at a rising edge. Returns on the following falling edge.
    task automatic send_beat(input logic [15:0] cur, input logic [15:0] tgt);
        if (gaps_on && $urandom_range(0, 11) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {tgt, cur};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
    endtask

    // shape_mode is only written with the pipe empty: every beat yields one
    // output beat, so an empty expectation queue means nothing is in flight.
    task automatic set_mode(input shape_mode_t m);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = m;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // A well-formed ramp: the first two beats carry a zero target (arm, then
    // re-arm in case the first beat ended a stale run), the rest are nonzero
    // targets with the odd stray zero thrown in as noise.
    task automatic run_phase(input shape_mode_t m, input int beats, input bit idle_on);
        logic [15:0] tgt;
        set_mode(m);
        gaps_on  = idle_on;
        stall_on = idle_on;
        for (int k = 0; k < beats; k++) begin
            if (k < 2 || $urandom_range(0, 63) == 0) begin
                tgt = '0;
            end else begin
                tgt = pick_value();
                if (tgt == '0) tgt = 16'h0001;
            end
            send_beat(pick_value(), tgt);
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // ---- directed part ----
        // unarmed: targets pass through
        set_mode(MODE_SINE);
        send_beat(16'sd100, 16'sd32767);
        send_beat(-16'sd32768, -16'sd32768);
        // zero target arms and is ramped on the same beat (step 1)
        send_beat(16'sd32767, 16'sd0);
        send_beat(-16'sd32768, 16'sd32767);
        send_beat(16'sd32767, -16'sd32768);
        send_beat(16'sd0, 16'sd1);
        // switch shape mid-run; the run carries on at the present step
        set_mode(MODE_LINEAR);
        send_beat(-16'sd32768, 16'sd32767);
        send_beat(-16'sd32768, 16'sd32767);
        send_beat(16'sd32767, -16'sd32768);
        send_beat(-16'sd1, 16'sd0);
        set_mode(MODE_COSINE);
        send_beat(-16'sd32768, 16'sd32767);
        send_beat(16'sd32767, -16'sd32768);
        send_beat(16'sd12345, -16'sd1);
        // unused selector: pass-through, a zero target still arms, steps held
        set_mode(MODE_BYPASS);
        send_beat(-16'sd32768, 16'sd32767);
        send_beat(16'sd5, 16'sd0);
        send_beat(16'sd32767, -16'sd32768);
        set_mode(MODE_SINE);
        send_beat(-16'sd32768, 16'sd32767);
        send_beat(16'sd32767, -16'sd32768);
        send_beat(-16'sd32768, -16'sd1);

        // ---- random part ----
        // 14 steps are done after the directed beats and every later beat is
        // ramped: sine and linear bring the count to 264, the first cosine
        // phase to 564, and the closing cosine phase passes 600 on its 37th
        // beat, so that run ends; later beats pass through unless a zero re-arms it.
        run_phase(MODE_SINE, 130, $urandom_range(0, 3) != 0);
        run_phase(MODE_LINEAR, 120, $urandom_range(0, 3) != 0);
        run_phase(MODE_COSINE, 300, $urandom_range(0, 3) != 0);
        // closing stretch at full rate
        run_phase(MODE_COSINE, 60, 1'b0);
        s_tvalid = 1'b0;

        // drain, then keep watching for stray beats
        while (pending != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);

        $display("checked %0d output beats, %0d of them ramped, %0d ramp runs ran out",
                 n_results, n_ramped, n_runs_ended);
        $display("shapes sine, linear, one minus cosine and bypass, incl. mid-run switches");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run (every beat gapped and stalled)
    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/ssr_pkg.sv
rtl/ssr_weight.sv
rtl/ssr_accum.sv
rtl/soft_start_setpoint_ramp.sv
test/ssr_checker.sv
test/testbench.sv
